/* design/edist_pkg.sv */
// edist_pkg: shared widths, payload structs and controller/datapath links
// for the streaming euclidean distance block. depends on nothing.

package edist_pkg;

	// element width of both vectors, signed fixed point
	localparam int unsigned ELEM_WIDTH = 16;

	// magnitude of a - b fits in ELEM_WIDTH bits, its square in twice that
	localparam int unsigned DIFF_W = ELEM_WIDTH + 1;
	localparam int unsigned MAG_W  = ELEM_WIDTH;
	localparam int unsigned SQ_W   = 2 * MAG_W;

	// running sum and its root
	localparam int unsigned SUM_W  = 48;
	localparam int unsigned ROOT_W = SUM_W / 2;
	localparam int unsigned REM_W  = ROOT_W + 3;
	localparam int unsigned CNT_W  = $clog2(ROOT_W);
	localparam int unsigned ADD_W  = ((SUM_W > SQ_W) ? SUM_W : SQ_W) + 1;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] a_value;
		logic signed [ELEM_WIDTH-1:0] b_value;
		logic                         a_last;
		logic                         b_last;
	} in_item_t;

	typedef struct packed {
		logic [ROOT_W-1:0] distance;
		logic              length_mismatch;
		logic              saturated;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic start;
		logic step;
		logic load_out;
	} edist_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_end;
		logic end_at_sum;
		logic root_last;
	} edist_status_t;

endpackage

/* design/euclidean_distance_stream.sv */
// euclidean_distance_stream: top level, controller plus datapath.
// depends on edist_pkg, edist_ctrl, edist_dp.

// Streams element pairs of two signed fixed point vectors and returns their
// L2 distance. While a vector is running, one pair is taken per cycle: the
// difference magnitude is registered, squared in the next cycle and added to
// a saturating 48-bit sum in the one after. An item carrying either last mark
// closes the vector: the input then stalls while the pipeline drains, the sum
// is handed to a restoring square root that retires two sum bits per cycle,
// and the floor root, the length mismatch flag and the saturation flag are
// loaded into the output register. The sum is cleared when the root starts,
// and the next vector may be fed while its predecessor's result still waits
// in the output register; only a second finished result waits for that
// register to empty.

module euclidean_distance_stream (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  edist_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output edist_pkg::out_item_t out_data
);
	import edist_pkg::*;

	// command and status links between sequencer and datapath
	edist_cmd_t    cmd;
	edist_status_t status;

	// sequencer: owns the handshakes and walks drain, root and unload
	edist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath: square pipeline, accumulator, root unit and result payload
	edist_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

/* design/edist_ctrl.sv */
// edist_ctrl: sequencing state machine and output valid flag.
// depends on edist_pkg.

module edist_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output edist_pkg::edist_cmd_t   cmd,
	input  edist_pkg::edist_status_t status
);
	import edist_pkg::*;

	typedef enum logic [4:0] {
		ST_ACCUM = 5'b00001,
		ST_DRAIN = 5'b00010,
		ST_START = 5'b00100,
		ST_ROOT  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_ACCUM);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = in_valid && in_ready;
		cmd.start    = (state_q == ST_START);
		cmd.step     = (state_q == ST_ROOT);
		cmd.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (cmd.accept && status.in_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.end_at_sum) state_d = ST_START;
			end
			ST_START: state_d = ST_ROOT;
			ST_ROOT: begin
				if (status.root_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (cmd.load_out) state_d = ST_ACCUM;
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/edist_dp.sv */
// edist_dp: difference/square pipeline, saturating sum, bit-pair square root
// and output payload register. depends on edist_pkg.

module edist_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  edist_pkg::in_item_t      in_data,
	output edist_pkg::out_item_t     out_data,
	input  edist_pkg::edist_cmd_t    cmd,
	output edist_pkg::edist_status_t status
);
	import edist_pkg::*;

	// stage 1: magnitude of the difference
	logic                valid_s1;
	logic [MAG_W-1:0]    mag_s1;
	logic                a_last_s1;
	logic                b_last_s1;
	// stage 2: exact square
	logic                valid_s2;
	logic [SQ_W-1:0]     sq_s2;
	logic                a_last_s2;
	logic                b_last_s2;
	// accumulator
	logic [SUM_W-1:0]    sum_q;
	logic                ovf_q;
	logic                mism_q;
	logic                sat_q;
	// square root unit
	logic [SUM_W-1:0]    xs_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	out_item_t           out_q;

	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] diff_abs;
	logic [ADD_W-1:0]         total;
	logic                     total_over;
	logic [REM_W-1:0]         rem_sh;
	logic [REM_W-1:0]         trial;
	logic                     fits;

	always_comb begin
		diff     = $signed({in_data.a_value[ELEM_WIDTH-1], in_data.a_value})
		         - $signed({in_data.b_value[ELEM_WIDTH-1], in_data.b_value});
		diff_abs = diff[DIFF_W-1] ? -diff : diff;
	end

	assign total      = ADD_W'(sum_q) + ADD_W'(sq_s2);
	assign total_over = (total[ADD_W-1:SUM_W] != '0);

	assign rem_sh = {rem_q[REM_W-3:0], xs_q[SUM_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	assign status.in_end     = in_data.a_last || in_data.b_last;
	assign status.end_at_sum = valid_s2 && (a_last_s2 || b_last_s2);
	assign status.root_last  = (cnt_q == '0);

	assign out_data = out_q;

	// pipeline valid bits and the saturating accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_q    <= '0;
			ovf_q    <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			valid_s2 <= valid_s1;
			if (cmd.start) begin
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else if (valid_s2) begin
				if (total_over) begin
					sum_q <= SUM_MAX;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= total[SUM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mag_s1    <= diff_abs[MAG_W-1:0];
			a_last_s1 <= in_data.a_last;
			b_last_s1 <= in_data.b_last;
		end
		if (valid_s1) begin
			sq_s2     <= mag_s1 * mag_s1;
			a_last_s2 <= a_last_s1;
			b_last_s2 <= b_last_s1;
		end
		if (status.end_at_sum) begin
			mism_q <= a_last_s2 ^ b_last_s2;
		end
		if (cmd.start) begin
			xs_q   <= sum_q;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_W'(ROOT_W - 1);
			sat_q  <= ovf_q;
		end else if (cmd.step) begin
			xs_q  <= {xs_q[SUM_W-3:0], 2'b00};
			cnt_q <= cnt_q - 1'b1;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			out_q.distance        <= root_q;
			out_q.length_mismatch <= mism_q;
			out_q.saturated       <= sat_q;
		end
	end

	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (!valid_s1 && !valid_s2))
		else $error("root started with items still in the pipeline");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (sum_q == '0 && !ovf_q))
		else $error("sum not cleared after root start");

	a_ovf_pins_max: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (sum_q == SUM_MAX))
		else $error("overflow flag set but sum not at maximum");

endmodule
